// ===== src/kwdt_pkg.sv =====
package kwdt_pkg;

    // request kinds
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } t_kind;

    // register word indexes
    localparam logic [9:0] REG_CTRL = 10'd0;
    localparam logic [9:0] REG_LOAD = 10'd1;
    localparam logic [9:0] REG_VAL  = 10'd2;
    localparam logic [9:0] REG_SR   = 10'd3;
    localparam logic [9:0] REG_KEY  = 10'd4;

    // control bit positions
    localparam int CTRL_EN    = 0;
    localparam int CTRL_INTEN = 1;
    localparam int CTRL_RSTEN = 2;
    localparam int CTRL_LOCK  = 3;

    // key values and reset value
    localparam logic [31:0] FEED_KEY     = 32'h5a5a_5a5a;
    localparam logic [31:0] LOCK_KEY     = 32'h1acc_e551;
    localparam logic [31:0] RELOAD_RESET = 32'h0000_ffff;

    // one incoming request
    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  word_index;
        logic [31:0] write_data;
    } t_req;

    // one result
    typedef struct packed {
        logic [31:0] read_data;
        logic        interrupt_line;
        logic        reset_request;
    } t_res;

endpackage

// ===== src/kwdt_in_stage.sv =====
module kwdt_in_stage
    import kwdt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_req i_req,
    input  logic i_fire,
    output logic o_stall,
    output logic o_valid,
    output t_req o_req
);

    logic r_valid;
    t_req r_req;
    logic w_take;

    // room when empty or when the held request moves on this cycle
    assign o_stall = r_valid & ~i_fire;
    assign w_take  = i_valid & ~o_stall;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_fire) begin
            r_valid <= 1'b0;
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_req <= i_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

// ===== src/kwdt_core.sv =====
module kwdt_core
    import kwdt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_req i_req,
    output t_res o_res
);

    logic [3:0]  r_ctrl,   n_ctrl;
    logic [31:0] r_reload, n_reload;
    logic [31:0] r_count,  n_count;
    logic        r_flag,   n_flag;
    logic        r_irq,    n_irq;
    logic [31:0] w_dec;
    logic [31:0] w_val;
    logic        w_timeout;
    logic [31:0] w_rd;

    assign w_dec = r_count - 32'd1;
    assign w_val = (r_ctrl[CTRL_EN] && r_flag) ? 32'd0 : r_count;

    // next state and result for the request in the input register
    always_comb begin
        n_ctrl    = r_ctrl;
        n_reload  = r_reload;
        n_count   = r_count;
        n_flag    = r_flag;
        n_irq     = r_irq;
        w_timeout = 1'b0;
        w_rd      = 32'd0;
        unique case (i_req.kind)
            KIND_TICK: begin
                if (r_ctrl[CTRL_EN]) begin
                    if (r_count == 32'd0) begin
                        w_timeout = ~r_flag;
                    end else begin
                        n_count   = w_dec;
                        w_timeout = (w_dec == 32'd0);
                    end
                end
            end
            KIND_READ: begin
                unique case (i_req.word_index)
                    REG_CTRL: w_rd = {28'd0, r_ctrl};
                    REG_LOAD: w_rd = r_reload;
                    REG_VAL:  w_rd = w_val;
                    REG_SR:   w_rd = {31'd0, r_flag};
                    default:  w_rd = 32'd0;
                endcase
            end
            KIND_WRITE: begin
                unique case (i_req.word_index)
                    REG_CTRL: begin
                        if (!r_ctrl[CTRL_LOCK]) begin
                            n_ctrl = {1'b0, i_req.write_data[2:0]};
                            if (!r_ctrl[CTRL_EN] && i_req.write_data[CTRL_EN]) begin
                                n_count = r_reload;
                            end else if (r_ctrl[CTRL_EN] && !i_req.write_data[CTRL_EN]
                                         && r_flag) begin
                                n_count = 32'd0;
                            end
                        end
                    end
                    REG_LOAD: begin
                        if (!r_ctrl[CTRL_LOCK]) begin
                            n_reload = i_req.write_data;
                        end
                    end
                    REG_SR: begin
                        if (i_req.write_data[0]) begin
                            n_flag = 1'b0;
                            n_irq  = 1'b0;
                        end
                    end
                    REG_KEY: begin
                        if (i_req.write_data == FEED_KEY) begin
                            n_flag  = 1'b0;
                            n_irq   = 1'b0;
                            n_count = r_reload;
                        end else if (i_req.write_data == LOCK_KEY) begin
                            n_ctrl[CTRL_LOCK] = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        // timeout effects
        if (w_timeout) begin
            n_flag = 1'b1;
            if (r_ctrl[CTRL_INTEN]) begin
                n_irq = 1'b1;
            end
        end
    end

    // watchdog state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl   <= 4'd0;
            r_reload <= RELOAD_RESET;
            r_count  <= RELOAD_RESET;
            r_flag   <= 1'b0;
            r_irq    <= 1'b0;
        end else if (i_fire) begin
            r_ctrl   <= n_ctrl;
            r_reload <= n_reload;
            r_count  <= n_count;
            r_flag   <= n_flag;
            r_irq    <= n_irq;
        end
    end

    // result of this request
    assign o_res.read_data      = w_rd;
    assign o_res.interrupt_line = n_irq;
    assign o_res.reset_request  = w_timeout & r_ctrl[CTRL_RSTEN];

`ifndef ASSERT_OFF
    a_rst_req_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res.reset_request) |-> (i_req.kind == KIND_TICK))
        else $error("reset request from a non-tick request");

    a_lock_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctrl[CTRL_LOCK] |=> r_ctrl[CTRL_LOCK])
        else $error("lock bit cleared without reset");

    a_irq_needs_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_irq |-> r_flag)
        else $error("interrupt high with timeout flag clear");

    a_irq_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_irq) |-> $past(i_fire && i_req.kind == KIND_TICK && r_ctrl[CTRL_INTEN]))
        else $error("interrupt raised without an enabled timeout tick");
`endif

endmodule

// ===== src/kwdt_out_stage.sv =====
module kwdt_out_stage
    import kwdt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_res i_res,
    input  logic i_stall,
    output logic o_fire,
    output logic o_valid,
    output t_res o_res
);

    logic r_valid;
    t_res r_res;

    // move a request in when the result register is empty or being taken
    assign o_fire = i_valid & (~r_valid | ~i_stall);

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_fire) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_fire) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== src/keyed_watchdog_timer_core.sv =====
// Keyed watchdog timer. Each request is a one-microsecond tick, a register
// read or a register write (CTRL, LOAD, VAL, SR, KEY) and yields exactly one
// result: read data, the interrupt level after the request, and a reset
// request pulse on the tick that times out with reset enable set. Requests
// pass through an input register, update the watchdog state on the way into
// a result register, and are accepted one per cycle while the result side
// does not stall; each result is held in the result register and shown on
// o_valid. The rate is set by the single state update per cycle between
// those two registers.
module keyed_watchdog_timer_core
    import kwdt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [1:0]  i_kind,
    input  logic [9:0]  i_word_index,
    input  logic [31:0] i_write_data,
    output logic        o_stall,
    output logic        o_valid,
    output logic [31:0] o_read_data,
    output logic        o_interrupt_line,
    output logic        o_reset_request,
    input  logic        i_stall
);

    t_req w_in_req;
    t_req w_req;
    logic w_req_valid;
    logic w_fire;
    t_res w_res;
    t_res w_out_res;

    assign w_in_req.kind       = i_kind;
    assign w_in_req.word_index = i_word_index;
    assign w_in_req.write_data = i_write_data;

    // input register
    kwdt_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_req   (w_in_req),
        .i_fire  (w_fire),
        .o_stall (o_stall),
        .o_valid (w_req_valid),
        .o_req   (w_req)
    );

    // watchdog state and request decode
    kwdt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    // result register
    kwdt_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_req_valid),
        .i_res   (w_res),
        .i_stall (i_stall),
        .o_fire  (w_fire),
        .o_valid (o_valid),
        .o_res   (w_out_res)
    );

    assign o_read_data      = w_out_res.read_data;
    assign o_interrupt_line = w_out_res.interrupt_line;
    assign o_reset_request  = w_out_res.reset_request;

endmodule

// ===== tb/tb_keyed_watchdog_timer_core.sv =====
module tb_keyed_watchdog_timer_core;
    import kwdt_pkg::*;

    // kind code with no defined action
    localparam logic [1:0] KIND_NONE = 2'd3;
    // receiver hold-off used to back up the pipeline
    localparam int LONG_HOLD = 60;
    // effective random requests per idling phase
    localparam int PHASE_ITEMS = 428;

    // bit-accurate watchdog prediction and result matching
    class wdt_scoreboard;
        logic [3:0]  ctl;
        logic [31:0] load_val;
        logic [31:0] count_val;
        logic        expired;
        logic        irq_out;
        t_res        expected_results[$];
        int          mismatches;

        function new();
            ctl        = '0;
            load_val   = RELOAD_RESET;
            count_val  = RELOAD_RESET;
            expired    = 1'b0;
            irq_out    = 1'b0;
            mismatches = 0;
        endfunction

        // apply one accepted request and queue the result it should give
        function void accept_request(logic [1:0] kind, logic [9:0] idx, logic [31:0] data);
            t_res res;
            logic old_en;
            logic fire;
            res = '0;
            case (kind)
                KIND_TICK: begin
                    if (ctl[CTRL_EN]) begin
                        fire = 1'b0;
                        if (count_val == 32'd0) begin
                            fire = !expired;
                        end else begin
                            count_val = count_val - 32'd1;
                            fire = (count_val == 32'd0);
                        end
                        if (fire) begin
                            expired = 1'b1;
                            if (ctl[CTRL_INTEN])
                                irq_out = 1'b1;
                            res.reset_request = ctl[CTRL_RSTEN];
                        end
                    end
                end
                KIND_READ: begin
                    case (idx)
                        REG_CTRL: res.read_data = {28'd0, ctl};
                        REG_LOAD: res.read_data = load_val;
                        REG_VAL:  res.read_data = (ctl[CTRL_EN] && expired) ? 32'd0 : count_val;
                        REG_SR:   res.read_data = {31'd0, expired};
                        default:  res.read_data = 32'd0;
                    endcase
                end
                KIND_WRITE: begin
                    case (idx)
                        REG_CTRL: begin
                            if (!ctl[CTRL_LOCK]) begin
                                old_en = ctl[CTRL_EN];
                                ctl    = {1'b0, data[2:0]};
                                if (!old_en && ctl[CTRL_EN])
                                    count_val = load_val;
                                else if (old_en && !ctl[CTRL_EN] && expired)
                                    count_val = 32'd0;
                            end
                        end
                        REG_LOAD: begin
                            if (!ctl[CTRL_LOCK])
                                load_val = data;
                        end
                        REG_SR: begin
                            if (data[0]) begin
                                expired = 1'b0;
                                irq_out = 1'b0;
                            end
                        end
                        REG_KEY: begin
                            if (data == FEED_KEY) begin
                                expired   = 1'b0;
                                irq_out   = 1'b0;
                                count_val = load_val;
                            end else if (data == LOCK_KEY) begin
                                ctl[CTRL_LOCK] = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            res.interrupt_line = irq_out;
            expected_results.push_back(res);
        endfunction

        // compare one accepted result with the oldest prediction
        function void match_result(logic [31:0] rd, logic irq, logic rst);
            t_res exp_res;
            if (expected_results.size() == 0) begin
                $error("unexpected result: read_data %h interrupt_line %b reset_request %b",
                       rd, irq, rst);
                mismatches++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (rd !== exp_res.read_data) begin
                $error("read_data: expected %h, actual %h", exp_res.read_data, rd);
                mismatches++;
            end
            if (irq !== exp_res.interrupt_line) begin
                $error("interrupt_line: expected %b, actual %b", exp_res.interrupt_line, irq);
                mismatches++;
            end
            if (rst !== exp_res.reset_request) begin
                $error("reset_request: expected %b, actual %b", exp_res.reset_request, rst);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_kind = '0;
    logic [9:0]  i_word_index = '0;
    logic [31:0] i_write_data = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_read_data;
    logic        o_interrupt_line;
    logic        o_reset_request;

    wdt_scoreboard board;
    int            send_gap_max = 4;
    int            recv_gap_max = 4;
    bit            hold_stall = 1'b0;

    keyed_watchdog_timer_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_kind           (i_kind),
        .i_word_index     (i_word_index),
        .i_write_data     (i_write_data),
        .o_stall          (o_stall),
        .o_valid          (o_valid),
        .o_read_data      (o_read_data),
        .o_interrupt_line (o_interrupt_line),
        .o_reset_request  (o_reset_request),
        .i_stall          (i_stall)
    );

    // clock
    always #4 i_clk = ~i_clk;

    // watch both handshakes
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            board.accept_request(i_kind, i_word_index, i_write_data);
        if (i_rst_n && o_valid && !i_stall)
            board.match_result(o_read_data, o_interrupt_line, o_reset_request);
    end

    // offer one request after a random gap and hold it until taken
    task automatic send_request(input logic [1:0] kind, input logic [9:0] idx,
                                input logic [31:0] data);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_word_index <= idx;
        i_write_data <= data;
        do @(posedge i_clk); while (o_stall);
    endtask

    // one random request, biased toward short loads, enables and feeds
    task automatic issue_random(input bit may_lock, output bit counted);
        int          pick;
        logic [1:0]  kind;
        logic [9:0]  idx;
        logic [31:0] data;
        pick    = $urandom_range(0, 99);
        data    = $urandom();
        idx     = 10'($urandom_range(0, 4));
        kind    = KIND_WRITE;
        counted = 1'b1;
        if (pick < 40) begin
            kind = KIND_TICK;
            idx  = 10'($urandom_range(0, 1023));
        end else if (pick < 55) begin
            kind = KIND_READ;
        end else if (pick < 59) begin
            kind = KIND_READ;
            idx  = 10'($urandom_range(0, 1023));
        end else if (pick < 61) begin
            kind    = KIND_NONE;
            idx     = 10'($urandom_range(0, 1023));
            counted = 1'b0;
        end else if (pick < 69) begin
            idx = REG_LOAD;
            if ($urandom_range(0, 7) != 0)
                data = $urandom_range(0, 12);
        end else if (pick < 79) begin
            idx = REG_CTRL;
            data[CTRL_EN] = ($urandom_range(0, 3) != 0);
        end else if (pick < 85) begin
            idx = REG_SR;
        end else if (pick < 94) begin
            idx  = REG_KEY;
            pick = $urandom_range(0, 9);
            if (pick < 6)
                data = FEED_KEY;
            else if (pick == 6 && may_lock)
                data = LOCK_KEY;
            if (!may_lock && data == LOCK_KEY)
                data = ~data;
        end else begin
            idx     = ($urandom_range(0, 1) != 0) ? REG_VAL : 10'($urandom_range(5, 1023));
            counted = 1'b0;
        end
        send_request(kind, idx, data);
    endtask

    // result side: random stalls, plus the long hold-off on request
    initial begin
        int wait_n;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_stall) begin
                wait_n     = LONG_HOLD;
                hold_stall = 1'b0;
            end else begin
                wait_n = $urandom_range(0, recv_gap_max);
            end
            if (wait_n > 0) begin
                i_stall <= 1'b1;
                repeat (wait_n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // stimulus and verdict
    initial begin
        int phase;
        int done;
        bit counted;
        board = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values and unmapped space
        send_request(KIND_READ, REG_CTRL, '0);
        send_request(KIND_READ, REG_LOAD, '0);
        send_request(KIND_READ, REG_VAL, '0);
        send_request(KIND_READ, REG_SR, '0);
        send_request(KIND_READ, REG_KEY, '0);
        send_request(KIND_READ, 10'h3ff, '0);
        send_request(KIND_WRITE, 10'h3ff, 32'hffff_ffff);
        send_request(KIND_WRITE, REG_VAL, 32'hffff_ffff);
        send_request(KIND_NONE, 10'h3ff, 32'hffff_ffff);
        send_request(KIND_TICK, REG_CTRL, '0);
        // zero load expires on the first tick, then no second timeout
        send_request(KIND_WRITE, REG_LOAD, 32'h0);
        send_request(KIND_WRITE, REG_CTRL, 32'hffff_ffff);
        send_request(KIND_TICK, REG_CTRL, '0);
        send_request(KIND_TICK, 10'h3ff, 32'hffff_ffff);
        send_request(KIND_READ, REG_SR, '0);
        // disable while timed out, interrupt stays latched
        send_request(KIND_WRITE, REG_CTRL, 32'h0);
        send_request(KIND_READ, REG_VAL, '0);
        // re-enable after timeout reloads but keeps the flag
        send_request(KIND_WRITE, REG_LOAD, 32'hffff_ffff);
        send_request(KIND_WRITE, REG_CTRL, 32'h1);
        send_request(KIND_TICK, REG_CTRL, '0);
        send_request(KIND_READ, REG_VAL, '0);
        // sr clear needs bit 0
        send_request(KIND_WRITE, REG_SR, 32'hffff_fffe);
        send_request(KIND_WRITE, REG_SR, 32'h1);
        send_request(KIND_READ, REG_VAL, '0);
        // other key values do nothing, feed reloads
        send_request(KIND_WRITE, REG_LOAD, 32'h1);
        send_request(KIND_WRITE, REG_KEY, 32'h5a5a_5a5b);
        send_request(KIND_WRITE, REG_KEY, FEED_KEY);
        send_request(KIND_TICK, REG_CTRL, '0);

        // random traffic over idling patterns
        for (phase = 0; phase < 4; phase++) begin
            send_gap_max = (phase == 0 || phase == 2) ? 4 : 0;
            recv_gap_max = (phase == 0 || phase == 3) ? 4 : 0;
            if (phase >= 2)
                hold_stall = 1'b1;
            done = 0;
            while (done < PHASE_ITEMS) begin
                issue_random(1'b0, counted);
                if (counted)
                    done++;
            end
        end

        // lock: ctrl and load become read-only for the rest of the run
        send_gap_max = 4;
        recv_gap_max = 4;
        send_request(KIND_WRITE, REG_LOAD, 32'h4);
        send_request(KIND_WRITE, REG_CTRL, 32'h3);
        send_request(KIND_WRITE, REG_KEY, LOCK_KEY);
        send_request(KIND_READ, REG_CTRL, '0);
        send_request(KIND_WRITE, REG_CTRL, 32'h0);
        send_request(KIND_WRITE, REG_LOAD, 32'h3);
        send_request(KIND_READ, REG_LOAD, '0);
        for (done = 0; done < 60; done++)
            issue_random(1'b1, counted);
        i_valid <= 1'b0;

        // drain, then allow for the pipeline depth
        while (board.expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0 && board.expected_results.size() == 0)
            $display("tb_keyed_watchdog_timer_core passed");
        else
            $display("tb_keyed_watchdog_timer_core failed");
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("tb_keyed_watchdog_timer_core failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/kwdt_pkg.sv
src/kwdt_in_stage.sv
src/kwdt_core.sv
src/kwdt_out_stage.sv
src/keyed_watchdog_timer_core.sv
tb/tb_keyed_watchdog_timer_core.sv
